// ===== rtl/core/grid_lattice_path_count_top_assert.svh =====
// Assertion macros shared by the lattice path counter RTL.
// Each macro expects clk and arst_n in scope where it is used.
`ifndef GRID_LATTICE_PATH_COUNT_TOP_ASSERT_SVH
`define GRID_LATTICE_PATH_COUNT_TOP_ASSERT_SVH

// same-cycle implication
`define GLPC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GLPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/glpc_pkg.sv =====
// Shared widths, constants and controller/datapath interface types
// for the lattice path counter. No dependencies.
package glpc_pkg;

	localparam int DIM_W  = 11;             // rows/cols port width
	localparam int IDX_W  = 10;             // base, steps, step index
	localparam int ACC_W  = 31;             // running count
	localparam int FAC_W  = IDX_W + 1;      // base + i
	localparam int PROD_W = ACC_W + FAC_W;  // acc * (base + i)
	localparam int CNT_W  = $clog2(PROD_W);

	localparam logic [DIM_W-1:0] MAX_DIM     = 11'd1024;
	localparam logic [ACC_W-1:0] COUNT_LIMIT = 31'h7FFF_FFFF;

	typedef struct packed {
		logic load;      // capture a new item
		logic mul;       // form acc * (base + i)
		logic div_step;  // one restoring division bit
		logic chk;       // take quotient, test limit, advance i
	} ctrl_cmd_t;

	typedef struct packed {
		logic trivial;   // zero-size grid or single column
		logic div_last;  // final division bit this cycle
		logic ovf_now;   // quotient above count limit
		logic last_step; // i equals steps
	} dp_status_t;

endpackage

// ===== rtl/core/glpc_dp.sv =====
// Datapath of the lattice path counter: input clamp, 31x11 multiplier,
// bit-serial exact divider by the step index. Uses glpc_pkg.
module glpc_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  glpc_pkg::ctrl_cmd_t               cmd,
	input  logic [glpc_pkg::DIM_W-1:0]        rows,
	input  logic [glpc_pkg::DIM_W-1:0]        cols,
	output glpc_pkg::dp_status_t              status,
	output logic [glpc_pkg::ACC_W-1:0]        path_count,
	output logic                              overflow
);

	logic [glpc_pkg::DIM_W-1:0]  rows_c, cols_c;
	logic [glpc_pkg::DIM_W-1:0]  base_w, steps_w;
	logic [glpc_pkg::IDX_W-1:0]  base_q, steps_q, i_q;
	logic [glpc_pkg::ACC_W-1:0]  acc_q;
	logic                        zero_q, ovf_q;
	logic [glpc_pkg::FAC_W-1:0]  factor;
	logic [glpc_pkg::PROD_W-1:0] quo_q;
	logic [glpc_pkg::IDX_W-1:0]  rem_q;
	logic [glpc_pkg::CNT_W-1:0]  cnt_q;
	logic [glpc_pkg::IDX_W:0]    trial, divisor;
	logic                        ge;

	assign rows_c  = (rows > glpc_pkg::MAX_DIM) ? glpc_pkg::MAX_DIM : rows;
	assign cols_c  = (cols > glpc_pkg::MAX_DIM) ? glpc_pkg::MAX_DIM : cols;
	assign base_w  = rows_c - glpc_pkg::DIM_W'(1);
	assign steps_w = cols_c - glpc_pkg::DIM_W'(1);

	assign factor  = {1'b0, base_q} + {1'b0, i_q};
	assign divisor = {1'b0, i_q};
	assign trial   = {rem_q, quo_q[glpc_pkg::PROD_W-1]};
	assign ge      = (trial >= divisor);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (cmd.load) begin
				zero_q <= (rows == '0) || (cols == '0);
				ovf_q  <= 1'b0;
			end
			if (cmd.mul)
				cnt_q <= '0;
			else if (cmd.div_step)
				cnt_q <= cnt_q + glpc_pkg::CNT_W'(1);
			if (cmd.chk && status.ovf_now)
				ovf_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q  <= base_w[glpc_pkg::IDX_W-1:0];
			steps_q <= steps_w[glpc_pkg::IDX_W-1:0];
			i_q     <= glpc_pkg::IDX_W'(1);
			acc_q   <= glpc_pkg::ACC_W'(1);
		end
		if (cmd.mul) begin
			quo_q <= glpc_pkg::PROD_W'(acc_q) * glpc_pkg::PROD_W'(factor);
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			// restoring division, quotient bits shift in where dividend bits leave
			quo_q <= {quo_q[glpc_pkg::PROD_W-2:0], ge};
			rem_q <= ge ? glpc_pkg::IDX_W'(trial - divisor) : trial[glpc_pkg::IDX_W-1:0];
		end
		if (cmd.chk && !status.ovf_now) begin
			acc_q <= quo_q[glpc_pkg::ACC_W-1:0];
			i_q   <= i_q + glpc_pkg::IDX_W'(1);
		end
	end

	assign status.trivial   = zero_q || (steps_q == '0);
	assign status.div_last  = (cnt_q == glpc_pkg::CNT_W'(glpc_pkg::PROD_W - 1));
	assign status.ovf_now   = (quo_q > glpc_pkg::PROD_W'(glpc_pkg::COUNT_LIMIT));
	assign status.last_step = (i_q == steps_q);

	assign path_count = zero_q ? '0 : (ovf_q ? glpc_pkg::COUNT_LIMIT : acc_q);
	assign overflow   = ovf_q && !zero_q;

endmodule

// ===== rtl/core/glpc_ctrl.sv =====
// Controller of the lattice path counter: sequences load, multiply,
// divide and check steps, then hands off to the output stage. Uses glpc_pkg.
module glpc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 out_free,
	output logic                 out_load,
	input  glpc_pkg::dp_status_t status,
	output glpc_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_START = 6'b000010,
		ST_MUL   = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_CHK   = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		in_ready     = 1'b0;
		out_load     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_START;
				end
			end
			ST_START: begin
				state_d = status.trivial ? ST_FIN : ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last)
					state_d = ST_CHK;
			end
			ST_CHK: begin
				cmd.chk = 1'b1;
				state_d = (status.ovf_now || status.last_step) ? ST_FIN : ST_MUL;
			end
			ST_FIN: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ===== rtl/core/grid_lattice_path_count_top.sv =====
// Lattice path counter, top level: stream ports, output register,
// controller and datapath. Uses glpc_pkg, glpc_ctrl, glpc_dp and the assert header.
//
// Usage:
//   Input channel s_*: one transaction carries a grid's rows and cols. Values
//   above 1024 count as 1024; a zero in either gives count 0.
//   Output channel m_*: one transaction per input with the number of
//   monotone corner-to-corner paths, C(rows+cols-2, cols-1), saturated at
//   2147483647 with overflow set in m_tuser.
//   Work: a zero-size grid or one column goes straight to the result;
//   otherwise k product steps are done (k <= cols-1, fewer when the count
//   saturates early). Each step is one multiply, a pass of the bit-serial
//   divider and one check; the divider dominates. One item is worked on at a time.
//   The next input is taken as soon as the result moves to the output
//   register, so a stalled receiver only holds the block once a second
//   result is finished.
//   Reset: arst_n clears the controller and the output valid; no result is
//   pending afterwards.
`include "grid_lattice_path_count_top_assert.svh"

module grid_lattice_path_count_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [10:0] rows, [21:11] cols, [23:22] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [30:0] path_count, [31] zero
	output logic        m_tuser    // [0] overflow
);

	glpc_pkg::ctrl_cmd_t          cmd;
	glpc_pkg::dp_status_t         status;
	logic                         out_free, out_load;
	logic [glpc_pkg::ACC_W-1:0]   dp_count;
	logic                         dp_ovf;
	logic                         m_tvalid_q;
	logic [glpc_pkg::ACC_W-1:0]   count_q;
	logic                         ovf_q;

	assign out_free = !m_tvalid_q || m_tready;

	glpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_free (out_free),
		.out_load (out_load),
		.status   (status),
		.cmd      (cmd)
	);

	glpc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.rows       (s_tdata[10:0]),
		.cols       (s_tdata[21:11]),
		.status     (status),
		.path_count (dp_count),
		.overflow   (dp_ovf)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (out_load)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			count_q <= dp_count;
			ovf_q   <= dp_ovf;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, count_q};
	assign m_tuser  = ovf_q;

	`GLPC_ASSERT_SAME(a_ovf_sat, m_tvalid_q && ovf_q, count_q == glpc_pkg::COUNT_LIMIT,
		"overflow flagged without saturated count")
	`GLPC_ASSERT_SAME(a_load_free, out_load, !m_tvalid_q || m_tready,
		"output register overwritten while a result waits")
	`GLPC_ASSERT_NEXT(a_busy_after_in, s_tvalid && s_tready, !s_tready,
		"second input taken while an item is in work")

endmodule
